// ----- design/gffb_pkg.sv -----
// gffb_pkg: shared types and constants of the grid flood fill block.
// No dependencies; used by grid_flood_fill_bfs and gffb_checker.
`timescale 1ns / 1ps

package gffb_pkg;

    typedef enum logic [1:0] {
        CMD_PLACE = 2'd0,
        CMD_SEED  = 2'd1,
        CMD_STEP  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_ACCEPTED  = 3'd0,
        KIND_GROWN     = 3'd1,
        KIND_EMPTY     = 3'd2,
        KIND_SEED_DROP = 3'd3,
        KIND_GROWN_NOQ = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_POP,
        ST_NBR,
        ST_CHK,
        ST_END,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] color;
        logic [5:0]  cy;
        logic [5:0]  cx;
        logic [5:0]  py;
        logic [5:0]  px;
    } res_t;

    localparam int NUM_DIRS = 8;

    // neighbour visiting order
    localparam logic signed [1:0] DIR_DX [NUM_DIRS] = '{
        2'sd1, -2'sd1, 2'sd0, 2'sd0, -2'sd1, 2'sd1, 2'sd1, -2'sd1
    };
    localparam logic signed [1:0] DIR_DY [NUM_DIRS] = '{
        2'sd0, 2'sd0, 2'sd1, -2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd1
    };

endpackage

// ----- design/grid_flood_fill_bfs.sv -----
// grid_flood_fill_bfs: breadth-first 8-connected flood fill with occupancy
// bitmap and frontier queue held in synchronous memories. Uses gffb_pkg.
`timescale 1ns / 1ps

//  channel  | dir | tuser       | tdata                                   | tlast
//  s_axis   | in  | command     | cell_x, cell_y, cell_color              | -
//  m_axis   | out | kind        | parent_x, parent_y, child_x, child_y,   | last
//           |     |             | child_color                             |
//
// Place, seed, unused commands and a step on an empty queue go from idle to
// the flush state. A step that pops goes through the pop state, then the
// neighbour state for each direction in turn with a check state after each
// in-grid one, then end and flush; one occupancy read-modify-write at a
// time, with a registered read. After reset the bitmap is swept clear with
// s_axis_tready low. A stalled m_axis holds a step once its next word is found.

module grid_flood_fill_bfs #(
    parameter int GRID_COLS   = 64,
    parameter int GRID_ROWS   = 64,
    parameter int QUEUE_DEPTH = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // cell_x[5:0], cell_y[11:6], cell_color[43:12]
    input  logic [1:0]  s_axis_tuser,  // command

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // parent_x[5:0], parent_y[11:6], child_x[17:12],
                                       // child_y[23:18], child_color[55:24]
    output logic [2:0]  m_axis_tuser,  // kind
    output logic        m_axis_tlast
);

    localparam int XW    = (GRID_COLS > 64) ? $clog2(GRID_COLS) : 6;
    localparam int YW    = (GRID_ROWS > 64) ? $clog2(GRID_ROWS) : 6;
    localparam int CELLS = GRID_COLS * GRID_ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int QAW   = $clog2(QUEUE_DEPTH);
    localparam int QCW   = $clog2(QUEUE_DEPTH + 1);
    localparam int QEW   = XW + YW + 32;

    gffb_pkg::state_t state_reg, state_next;

    logic [AW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [2:0]     dir_reg, dir_next;
    logic [XW-1:0]  px_reg, px_next;
    logic [YW-1:0]  py_reg, py_next;
    logic [31:0]    pc_reg, pc_next;
    logic           held_valid_reg, held_valid_next;
    gffb_pkg::res_t held_reg, held_next;
    logic           out_valid_reg, out_valid_next;
    gffb_pkg::res_t out_reg, out_next;
    logic           out_last_reg, out_last_next;
    logic [QAW-1:0] head_reg, head_next;
    logic [QAW-1:0] tail_reg, tail_next;
    logic [QCW-1:0] count_reg, count_next;

    logic           occ_mem [CELLS];
    logic           occ_rd_reg;
    logic           occ_we, occ_wdata, occ_re;
    logic [AW-1:0]  occ_waddr, occ_raddr;

    logic [QEW-1:0] q_mem [QUEUE_DEPTH];
    logic [QEW-1:0] q_rd_reg;
    logic           q_we, q_re;
    logic [QEW-1:0] q_wdata;

    logic [5:0]     in_x, in_y;
    logic [31:0]    in_color;
    logic           accept, out_free, q_full, place_in;
    logic [AW-1:0]  place_addr;
    logic [QAW-1:0] tail_inc, head_inc;

    logic signed [XW+1:0] nx;
    logic signed [YW+1:0] ny;
    logic                 nb_in;
    logic [AW-1:0]        nb_addr;
    gffb_pkg::res_t       grown;

    assign in_x     = s_axis_tdata[5:0];
    assign in_y     = s_axis_tdata[11:6];
    assign in_color = s_axis_tdata[43:12];

    assign s_axis_tready = (state_reg == gffb_pkg::ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign q_full        = (count_reg == QCW'(QUEUE_DEPTH));
    assign tail_inc      = (tail_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign head_inc      = (head_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    assign place_in   = (int'(in_x) < GRID_COLS) && (int'(in_y) < GRID_ROWS);
    assign place_addr = AW'(int'(in_y) * GRID_COLS + int'(in_x));

    always_comb begin
        nx      = $signed({2'b00, px_reg}) + gffb_pkg::DIR_DX[dir_reg];
        ny      = $signed({2'b00, py_reg}) + gffb_pkg::DIR_DY[dir_reg];
        nb_in   = (nx >= 0) && (nx < $signed((XW+2)'(GRID_COLS)))
               && (ny >= 0) && (ny < $signed((YW+2)'(GRID_ROWS)));
        nb_addr = AW'(int'(ny[YW-1:0]) * GRID_COLS + int'(nx[XW-1:0]));

        grown       = '0;
        grown.kind  = q_full ? gffb_pkg::KIND_GROWN_NOQ : gffb_pkg::KIND_GROWN;
        grown.px    = px_reg[5:0];
        grown.py    = py_reg[5:0];
        grown.cx    = nx[5:0];
        grown.cy    = ny[5:0];
        grown.color = pc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= gffb_pkg::ST_CLEAR;
            clr_cnt_reg    <= '0;
            dir_reg        <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
        end else begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            dir_reg        <= dir_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        px_reg       <= px_next;
        py_reg       <= py_next;
        pc_reg       <= pc_next;
        held_reg     <= held_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge aclk) begin
        if (occ_we) begin
            occ_mem[occ_waddr] <= occ_wdata;
        end
        if (occ_re) begin
            occ_rd_reg <= occ_mem[occ_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (q_we) begin
            q_mem[tail_reg] <= q_wdata;
        end
        if (q_re) begin
            q_rd_reg <= q_mem[head_reg];
        end
    end

    always_comb begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        dir_next        = dir_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        pc_next         = pc_reg;
        held_valid_next = held_valid_reg;
        held_next       = held_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        occ_we          = 1'b0;
        occ_wdata       = 1'b0;
        occ_waddr       = nb_addr;
        occ_re          = 1'b0;
        occ_raddr       = nb_addr;
        q_we            = 1'b0;
        q_wdata         = {pc_reg, ny[YW-1:0], nx[XW-1:0]};
        q_re            = 1'b0;

        case (state_reg)
            gffb_pkg::ST_CLEAR: begin
                occ_we    = 1'b1;
                occ_waddr = clr_cnt_reg;
                if (clr_cnt_reg == AW'(CELLS - 1)) begin
                    state_next = gffb_pkg::ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end

            gffb_pkg::ST_IDLE: begin
                if (accept) begin
                    held_next       = '0;
                    held_next.kind  = gffb_pkg::KIND_ACCEPTED;
                    held_valid_next = 1'b1;
                    state_next      = gffb_pkg::ST_FLUSH;
                    case (gffb_pkg::cmd_t'(s_axis_tuser))
                        gffb_pkg::CMD_PLACE: begin
                            occ_we    = place_in;
                            occ_wdata = 1'b1;
                            occ_waddr = place_addr;
                        end
                        gffb_pkg::CMD_SEED: begin
                            if (q_full) begin
                                held_next.kind = gffb_pkg::KIND_SEED_DROP;
                            end else begin
                                q_we       = 1'b1;
                                q_wdata    = {in_color, YW'(in_y), XW'(in_x)};
                                tail_next  = tail_inc;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        gffb_pkg::CMD_STEP: begin
                            if (count_reg == '0) begin
                                held_next.kind = gffb_pkg::KIND_EMPTY;
                            end else begin
                                q_re            = 1'b1;
                                head_next       = head_inc;
                                count_next      = count_reg - 1'b1;
                                held_valid_next = 1'b0;
                                state_next      = gffb_pkg::ST_POP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            gffb_pkg::ST_POP: begin
                px_next    = q_rd_reg[XW-1:0];
                py_next    = q_rd_reg[XW+YW-1:XW];
                pc_next    = q_rd_reg[QEW-1:XW+YW];
                dir_next   = '0;
                state_next = gffb_pkg::ST_NBR;
            end

            gffb_pkg::ST_NBR: begin
                if (nb_in) begin
                    occ_re     = 1'b1;
                    state_next = gffb_pkg::ST_CHK;
                end else if (dir_reg == 3'(gffb_pkg::NUM_DIRS - 1)) begin
                    state_next = gffb_pkg::ST_END;
                end else begin
                    dir_next = dir_reg + 1'b1;
                end
            end

            gffb_pkg::ST_CHK: begin
                // the previous grown word can only leave once the next is known
                if (occ_rd_reg || !held_valid_reg || out_free) begin
                    if (!occ_rd_reg) begin
                        occ_we    = 1'b1;
                        occ_wdata = 1'b1;
                        if (!q_full) begin
                            q_we       = 1'b1;
                            tail_next  = tail_inc;
                            count_next = count_reg + 1'b1;
                        end
                        if (held_valid_reg) begin
                            out_next       = held_reg;
                            out_last_next  = 1'b0;
                            out_valid_next = 1'b1;
                        end
                        held_next       = grown;
                        held_valid_next = 1'b1;
                    end
                    if (dir_reg == 3'(gffb_pkg::NUM_DIRS - 1)) begin
                        state_next = gffb_pkg::ST_END;
                    end else begin
                        dir_next   = dir_reg + 1'b1;
                        state_next = gffb_pkg::ST_NBR;
                    end
                end
            end

            gffb_pkg::ST_END: begin
                if (!held_valid_reg) begin
                    held_next       = '0;
                    held_next.kind  = gffb_pkg::KIND_EMPTY;
                    held_next.px    = px_reg[5:0];
                    held_next.py    = py_reg[5:0];
                    held_next.color = pc_reg;
                    held_valid_next = 1'b1;
                end
                state_next = gffb_pkg::ST_FLUSH;
            end

            gffb_pkg::ST_FLUSH: begin
                if (out_free) begin
                    out_next        = held_reg;
                    out_last_next   = 1'b1;
                    out_valid_next  = 1'b1;
                    held_valid_next = 1'b0;
                    state_next      = gffb_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = gffb_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.color, out_reg.cy, out_reg.cx, out_reg.py, out_reg.px};
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ----- design/gffb_checker.sv -----
// gffb_checker: port-level assertions for grid_flood_fill_bfs, bound to the top.
// Uses gffb_pkg for result kinds.
`timescale 1ns / 1ps

module gffb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [47:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // bitmap sweep keeps the input closed straight after reset
    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_axis_tready)
        else $error("s_axis_tready high right after reset");

    a_no_word_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("m_axis_tvalid high right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled output word changed");

    // place and seed answers are single, empty words
    a_simple_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == gffb_pkg::KIND_ACCEPTED
                          || m_axis_tuser == gffb_pkg::KIND_SEED_DROP)
            |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("accepted or dropped word carries data");

    a_child_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == gffb_pkg::KIND_GROWN
                          || m_axis_tuser == gffb_pkg::KIND_GROWN_NOQ)
            |-> m_axis_tdata[11:0] != m_axis_tdata[23:12])
        else $error("grown child equals its parent");

endmodule

bind grid_flood_fill_bfs gffb_checker u_gffb_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ----- tb/grid_flood_fill_bfs_tb.sv -----
// Self-checking bench for grid_flood_fill_bfs: drives place, seed and step words,
// predicts every result word from its own occupancy map and frontier queue.
// Depends on gffb_pkg and the grid_flood_fill_bfs top level.
`timescale 1ns / 1ps

module grid_flood_fill_bfs_tb;

    localparam int GRID_COLS   = 64;
    localparam int GRID_ROWS   = 64;
    localparam int QUEUE_DEPTH = 4096;
    localparam int RANDOM_WORDS = 250;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    typedef struct {
        gffb_pkg::kind_t kind;
        logic [5:0]      px;
        logic [5:0]      py;
        logic [5:0]      cx;
        logic [5:0]      cy;
        logic [31:0]     color;
        logic            last;
    } growth_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // cell_x, cell_y, cell_color
    logic [1:0]  s_axis_tuser = '0;   // command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;        // parent_x, parent_y, child_x, child_y, child_color
    logic [2:0]  m_axis_tuser;        // kind
    logic        m_axis_tlast;

    grid_flood_fill_bfs #(
        .GRID_COLS   (GRID_COLS),
        .GRID_ROWS   (GRID_ROWS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // predicted block state
    bit          occupied [GRID_COLS*GRID_ROWS];
    logic [5:0]  front_x [QUEUE_DEPTH];
    logic [5:0]  front_y [QUEUE_DEPTH];
    logic [31:0] front_color [QUEUE_DEPTH];
    int          front_head = 0;
    int          front_tail = 0;
    int          front_count = 0;

    growth_word_t pending_edges [$];
    growth_word_t checked_word;
    int           mismatches = 0;
    int           src_pct = 20;
    int           sink_pct = 20;
    int           sink_hold = 0;

    function automatic int pick_gap(input int pct);
        if ($urandom_range(0, 99) >= pct) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [5:0] pick_coord();
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
                0: return 6'd0;
                1: return 6'd1;
                2: return 6'd62;
                default: return 6'd63;
            endcase
        end
        return 6'($urandom_range(0, 63));
    endfunction

    function automatic growth_word_t make_word(input gffb_pkg::kind_t kind,
                                               input logic [5:0] px, input logic [5:0] py,
                                               input logic [5:0] cx, input logic [5:0] cy,
                                               input logic [31:0] color);
        growth_word_t w;
        w.kind  = kind;
        w.px    = px;
        w.py    = py;
        w.cx    = cx;
        w.cy    = cy;
        w.color = color;
        w.last  = 1'b0;
        return w;
    endfunction

    function automatic bit frontier_push(input logic [5:0] x, input logic [5:0] y,
                                         input logic [31:0] color);
        if (front_count >= QUEUE_DEPTH) return 1'b0;
        front_x[front_tail]     = x;
        front_y[front_tail]     = y;
        front_color[front_tail] = color;
        front_tail  = (front_tail + 1) % QUEUE_DEPTH;
        front_count = front_count + 1;
        return 1'b1;
    endfunction

    task automatic predict_fill(input logic [1:0] cmd, input logic [5:0] x,
                                input logic [5:0] y, input logic [31:0] color);
        growth_word_t    batch [$];
        logic [5:0]      px;
        logic [5:0]      py;
        logic [31:0]     pc;
        int              nx;
        int              ny;
        int              d;
        gffb_pkg::kind_t k;
        if (cmd == gffb_pkg::CMD_PLACE) begin
            occupied[int'(y) * GRID_COLS + int'(x)] = 1'b1;
            batch = {batch, make_word(gffb_pkg::KIND_ACCEPTED, '0, '0, '0, '0, '0)};
        end else if (cmd == gffb_pkg::CMD_SEED) begin
            k = frontier_push(x, y, color) ? gffb_pkg::KIND_ACCEPTED
                                           : gffb_pkg::KIND_SEED_DROP;
            batch = {batch, make_word(k, '0, '0, '0, '0, '0)};
        end else if (cmd == gffb_pkg::CMD_STEP) begin
            if (front_count == 0) begin
                batch = {batch, make_word(gffb_pkg::KIND_EMPTY, '0, '0, '0, '0, '0)};
            end else begin
                px = front_x[front_head];
                py = front_y[front_head];
                pc = front_color[front_head];
                front_head  = (front_head + 1) % QUEUE_DEPTH;
                front_count = front_count - 1;
                for (d = 0; d < gffb_pkg::NUM_DIRS; d++) begin
                    nx = int'(px) + int'(gffb_pkg::DIR_DX[d]);
                    ny = int'(py) + int'(gffb_pkg::DIR_DY[d]);
                    if (nx >= 0 && nx < GRID_COLS && ny >= 0 && ny < GRID_ROWS &&
                        !occupied[ny * GRID_COLS + nx]) begin
                        occupied[ny * GRID_COLS + nx] = 1'b1;
                        k = frontier_push(6'(nx), 6'(ny), pc) ? gffb_pkg::KIND_GROWN
                                                               : gffb_pkg::KIND_GROWN_NOQ;
                        batch = {batch, make_word(k, px, py, 6'(nx), 6'(ny), pc)};
                    end
                end
                if (batch.size() == 0)
                    batch = {batch, make_word(gffb_pkg::KIND_EMPTY, px, py, '0, '0, pc)};
            end
        end else begin
            batch = {batch, make_word(gffb_pkg::KIND_ACCEPTED, '0, '0, '0, '0, '0)};
        end
        batch[batch.size() - 1].last = 1'b1;
        pending_edges = {pending_edges, batch};
    endtask

    // called at a rising edge; returns at the edge where the word was taken
    task automatic send_word(input logic [1:0] cmd, input logic [5:0] x,
                             input logic [5:0] y, input logic [31:0] color);
        int gap;
        gap = pick_gap(src_pct);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {4'b0000, color, y, x};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        predict_fill(cmd, x, y, color);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_edges.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (sink_hold == 0) sink_hold = pick_gap(sink_pct);
        if (sink_hold > 0) begin
            m_axis_tready <= 1'b0;
            sink_hold = sink_hold - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_edges.size() == 0) begin
                $display("%0t unexpected word: expected none, actual tuser %h tdata %h tlast %b",
                         $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
                mismatches++;
            end else begin
                checked_word = pending_edges[0];
                pending_edges.delete(0);
                compare_field("kind", 32'(checked_word.kind), 32'(m_axis_tuser));
                compare_field("parent_x", 32'(checked_word.px), 32'(m_axis_tdata[5:0]));
                compare_field("parent_y", 32'(checked_word.py), 32'(m_axis_tdata[11:6]));
                compare_field("child_x", 32'(checked_word.cx), 32'(m_axis_tdata[17:12]));
                compare_field("child_y", 32'(checked_word.cy), 32'(m_axis_tdata[23:18]));
                compare_field("child_color", checked_word.color, m_axis_tdata[55:24]);
                compare_field("last", 32'(checked_word.last), 32'(m_axis_tlast));
            end
        end
    end

    // empty step, spare command, place at both far corners
    task automatic test_empty_and_spare();
        send_word(gffb_pkg::CMD_STEP, 6'd0, 6'd0, 32'h0);
        send_word(CMD_SPARE, 6'd63, 6'd63, 32'hFFFF_FFFF);
        send_word(gffb_pkg::CMD_PLACE, 6'd0, 6'd0, 32'hFFFF_FFFF);
        send_word(gffb_pkg::CMD_PLACE, 6'd63, 6'd63, 32'h0);
        wait_drained();
    endtask

    // corners clip growth; centre grows all eight; repeated seed finds no free cell
    task automatic test_boundary_growth();
        send_word(gffb_pkg::CMD_SEED, 6'd0, 6'd0, 32'hFFFF_FFFF);
        send_word(gffb_pkg::CMD_SEED, 6'd63, 6'd63, 32'h0000_0000);
        send_word(gffb_pkg::CMD_SEED, 6'd63, 6'd0, 32'h5555_5555);
        send_word(gffb_pkg::CMD_SEED, 6'd0, 6'd63, 32'hAAAA_AAAA);
        send_word(gffb_pkg::CMD_SEED, 6'd32, 6'd32, 32'h1234_5678);
        send_word(gffb_pkg::CMD_SEED, 6'd32, 6'd32, 32'h8765_4321);
        repeat (6) send_word(gffb_pkg::CMD_STEP, 6'd63, 6'd0, 32'hFFFF_FFFF);
        wait_drained();
    endtask

    task automatic test_random_growth();
        int sent;
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            case ($urandom_range(0, 3))
                0: begin src_pct = 0;  sink_pct = 0;  end
                1: begin src_pct = 10; sink_pct = 10; end
                2: begin src_pct = 40; sink_pct = 15; end
                default: begin src_pct = 15; sink_pct = 40; end
            endcase
            if ($urandom_range(0, 3) != 0) begin
                repeat ($urandom_range(0, 3)) begin
                    send_word(gffb_pkg::CMD_PLACE, pick_coord(), pick_coord(), $urandom());
                    sent++;
                end
                repeat ($urandom_range(1, 2)) begin
                    send_word(gffb_pkg::CMD_SEED, pick_coord(), pick_coord(), $urandom());
                    sent++;
                end
                repeat ($urandom_range(2, 8)) begin
                    send_word(gffb_pkg::CMD_STEP, 6'($urandom()), 6'($urandom()),
                              $urandom());
                    sent++;
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    send_word(2'($urandom()), 6'($urandom()), 6'($urandom()), $urandom());
                    sent++;
                end
            end
            if ($urandom_range(0, 7) == 0) wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_and_spare();
        test_boundary_growth();
        test_random_growth();
        repeat (40) @(posedge aclk);
        if (mismatches == 0 && pending_edges.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
